// ----- hw/rtl/sbl_pkg.sv -----
// Package for the source byte lexer: payload structs, token kinds, scan modes.
// Used by every module of the lexer; depends on nothing.
package sbl_pkg;

  localparam int OffsetBitsDef   = 32;
  localparam int KeywordCharsDef = 6;
  localparam int QueueDepth      = 8;
  localparam int OutOffBits      = 32;
  localparam int KindBits        = 5;

  typedef enum logic [4:0] {
    K_FUNC = 5'd0, K_SYMBOL = 5'd1, K_OPEN_PAREN = 5'd2, K_CLOSED_PAREN = 5'd3,
    K_COLON = 5'd4, K_OPEN_CURLY = 5'd5, K_CLOSED_CURLY = 5'd6, K_LOCAL = 5'd7,
    K_EQUALS = 5'd8, K_NUMBER = 5'd9, K_WHILE = 5'd10, K_GREATER = 5'd11,
    K_LESS_EQUALS = 5'd12, K_PLUS = 5'd13, K_MINUS_EQUALS = 5'd14, K_MINUS = 5'd15,
    K_SEMICOLON = 5'd16, K_COMMA = 5'd17, K_AND = 5'd18, K_REM = 5'd19,
    K_IF = 5'd20, K_ELSE = 5'd21, K_ASTERISK = 5'd22, K_EQUALS_EQUALS = 5'd23,
    K_RETURN = 5'd24, K_TRUE = 5'd25, K_FALSE = 5'd26, K_PLUS_EQUALS = 5'd27,
    K_END = 5'd28
  } kind_t;

  typedef enum logic [3:0] {
    M_IDLE, M_SYMBOL, M_NUMBER, M_EQ, M_LT, M_AMP, M_PLUS, M_MINUS,
    M_SLASH, M_COMMENT, M_ERROR
  } mode_t;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [31:0] start_offset;
    logic [31:0] end_offset;
    logic        lex_error;
    logic        run_last;
  } out_item_t;

  // Kind for a single-byte punctuation token; K_END means none.
  function automatic kind_t single_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      8'h28:   k = K_OPEN_PAREN;
      8'h29:   k = K_CLOSED_PAREN;
      8'h3a:   k = K_COLON;
      8'h7b:   k = K_OPEN_CURLY;
      8'h7d:   k = K_CLOSED_CURLY;
      8'h3e:   k = K_GREATER;
      8'h3b:   k = K_SEMICOLON;
      8'h2c:   k = K_COMMA;
      8'h25:   k = K_REM;
      8'h2a:   k = K_ASTERISK;
      default: k = K_END;
    endcase
    return k;
  endfunction

endpackage

// ----- hw/rtl/sbl_front.sv -----
// Front end of the lexer: takes one byte per beat, tracks the scan mode and
// writes up to three raw token records into the queue. Depends on sbl_pkg.
module sbl_front #(
  parameter int OFFSET_BITS   = sbl_pkg::OffsetBitsDef,
  parameter int KEYWORD_CHARS = sbl_pkg::KeywordCharsDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  sbl_pkg::in_item_t      item,
  output logic [1:0]             rec_cnt,
  output sbl_pkg::out_item_t     rec [3]
);

  localparam int WLEN_BITS = $clog2(KEYWORD_CHARS + 2);
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
  localparam logic [WLEN_BITS-1:0] KC = WLEN_BITS'(KEYWORD_CHARS);

  sbl_pkg::mode_t mode_r, mode_nxt;
  logic [8*KEYWORD_CHARS-1:0] word_r, word_nxt;
  logic [WLEN_BITS-1:0] wlen_r, wlen_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt, tstart_r, tstart_nxt;

  // Keyword match against the current word.
  function automatic logic [4:0] sym_kind(input logic [8*KEYWORD_CHARS-1:0] w,
                                          input logic [WLEN_BITS-1:0] l);
    logic [4:0] k;
    k = sbl_pkg::K_SYMBOL;
    if (l == WLEN_BITS'(5) && w == (8*KEYWORD_CHARS)'(40'h656c696877))
      k = sbl_pkg::K_WHILE;
    else if (l == WLEN_BITS'(4) && w == (8*KEYWORD_CHARS)'(32'h636e7566))
      k = sbl_pkg::K_FUNC;
    else if (l == WLEN_BITS'(5) && w == (8*KEYWORD_CHARS)'(40'h6c61636f6c))
      k = sbl_pkg::K_LOCAL;
    else if (l == WLEN_BITS'(2) && w == (8*KEYWORD_CHARS)'(16'h6669))
      k = sbl_pkg::K_IF;
    else if (l == WLEN_BITS'(4) && w == (8*KEYWORD_CHARS)'(32'h65736c65))
      k = sbl_pkg::K_ELSE;
    else if (l == WLEN_BITS'(6) && w == (8*KEYWORD_CHARS)'(48'h6e7275746572))
      k = sbl_pkg::K_RETURN;
    else if (l == WLEN_BITS'(4) && w == (8*KEYWORD_CHARS)'(32'h65757274))
      k = sbl_pkg::K_TRUE;
    else if (l == WLEN_BITS'(5) && w == (8*KEYWORD_CHARS)'(40'h65736c6166))
      k = sbl_pkg::K_FALSE;
    return k;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] sinc(input logic [OFFSET_BITS-1:0] v);
    return (v == OFF_MAX) ? v : v + 1'b1;
  endfunction

  logic [7:0] b;
  logic fin, used, is_sp, is_dig, is_al, is_sst;
  logic [OFFSET_BITS-1:0] p1;
  sbl_pkg::kind_t sk;

  always_comb begin
    b = item.source_byte;
    fin = item.final_byte;
    p1 = sinc(pos_r);
    is_sp = (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
    is_dig = (b >= 8'h30 && b <= 8'h39);
    is_al = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    is_sst = is_al || (b == 8'h5f);
    sk = sbl_pkg::single_kind(b);
  end

  // Record construction helper.
  function automatic sbl_pkg::out_item_t mk(input logic [4:0] k,
      input logic [OFFSET_BITS-1:0] s, input logic [OFFSET_BITS-1:0] e,
      input logic err);
    sbl_pkg::out_item_t r;
    r.token_kind = k;
    r.start_offset = 32'(s);
    r.end_offset = 32'(e);
    r.lex_error = err;
    r.run_last = 1'b0;
    return r;
  endfunction

  // Next state and records for the byte on the input.
  always_comb begin
    sbl_pkg::out_item_t r0, r1, r2;
    logic [1:0] n;
    logic [OFFSET_BITS-1:0] ts;
    mode_nxt = mode_r;
    word_nxt = word_r;
    wlen_nxt = wlen_r;
    pos_nxt = pos_r;
    tstart_nxt = tstart_r;
    used = 1'b0;
    n = 2'd0;
    r0 = '0; r1 = '0; r2 = '0;
    ts = tstart_r;
    if (mode_r != sbl_pkg::M_ERROR) begin
      unique case (mode_r)
        sbl_pkg::M_SYMBOL: begin
          if (is_sst || is_dig) begin
            used = 1'b1;
            if (wlen_r < KC) word_nxt[8*wlen_r +: 8] = b;
            if (wlen_r < KC + 1'b1) wlen_nxt = wlen_r + 1'b1;
          end else begin
            r0 = mk(sym_kind(word_r, wlen_r), ts, pos_r, 1'b0); n = 2'd1;
            mode_nxt = sbl_pkg::M_IDLE;
          end
        end
        sbl_pkg::M_NUMBER: begin
          if (is_dig) used = 1'b1;
          else begin
            r0 = mk(sbl_pkg::K_NUMBER, ts, pos_r, 1'b0); n = 2'd1;
            mode_nxt = sbl_pkg::M_IDLE;
          end
        end
        sbl_pkg::M_EQ, sbl_pkg::M_PLUS, sbl_pkg::M_MINUS: begin
          if (b == 8'h3d) begin
            used = 1'b1;
            r0 = mk(mode_r == sbl_pkg::M_EQ ? sbl_pkg::K_EQUALS_EQUALS :
                    mode_r == sbl_pkg::M_PLUS ? sbl_pkg::K_PLUS_EQUALS :
                    sbl_pkg::K_MINUS_EQUALS, ts, p1, 1'b0);
          end else begin
            r0 = mk(mode_r == sbl_pkg::M_EQ ? sbl_pkg::K_EQUALS :
                    mode_r == sbl_pkg::M_PLUS ? sbl_pkg::K_PLUS :
                    sbl_pkg::K_MINUS, ts, sinc(ts), 1'b0);
          end
          n = 2'd1;
          mode_nxt = sbl_pkg::M_IDLE;
        end
        sbl_pkg::M_LT, sbl_pkg::M_AMP, sbl_pkg::M_SLASH: begin
          used = 1'b1;
          if (b != (mode_r == sbl_pkg::M_LT ? 8'h3d :
                    mode_r == sbl_pkg::M_AMP ? 8'h26 : 8'h2f)) begin
            r0 = mk(sbl_pkg::K_FUNC, ts, sinc(ts), 1'b1); n = 2'd1;
            mode_nxt = sbl_pkg::M_ERROR;
          end else if (mode_r == sbl_pkg::M_SLASH) begin
            mode_nxt = sbl_pkg::M_COMMENT;
          end else begin
            r0 = mk(mode_r == sbl_pkg::M_LT ? sbl_pkg::K_LESS_EQUALS : sbl_pkg::K_AND,
                    ts, p1, 1'b0);
            n = 2'd1;
            mode_nxt = sbl_pkg::M_IDLE;
          end
        end
        sbl_pkg::M_COMMENT: begin
          used = 1'b1;
          if (b == 8'h0a) mode_nxt = sbl_pkg::M_IDLE;
        end
        default: mode_nxt = sbl_pkg::M_IDLE;
      endcase

      // Start of a new token from idle.
      if (!used && mode_nxt == sbl_pkg::M_IDLE) begin
        tstart_nxt = pos_r;
        priority if (is_sp) begin
        end else if (is_sst) begin
          mode_nxt = sbl_pkg::M_SYMBOL;
          word_nxt = '0;
          word_nxt[7:0] = b;
          wlen_nxt = WLEN_BITS'(1);
        end else if (is_dig) mode_nxt = sbl_pkg::M_NUMBER;
        else if (sk != sbl_pkg::K_END) begin
          if (n == 2'd0) r0 = mk(sk, pos_r, p1, 1'b0); else r1 = mk(sk, pos_r, p1, 1'b0);
          n = n + 2'd1;
        end else if (b == 8'h3d) mode_nxt = sbl_pkg::M_EQ;
        else if (b == 8'h2b) mode_nxt = sbl_pkg::M_PLUS;
        else if (b == 8'h2d) mode_nxt = sbl_pkg::M_MINUS;
        else if (b == 8'h3c) mode_nxt = sbl_pkg::M_LT;
        else if (b == 8'h26) mode_nxt = sbl_pkg::M_AMP;
        else if (b == 8'h2f) mode_nxt = sbl_pkg::M_SLASH;
        else begin
          if (n == 2'd0) r0 = mk(sbl_pkg::K_FUNC, pos_r, p1, 1'b1);
          else r1 = mk(sbl_pkg::K_FUNC, pos_r, p1, 1'b1);
          n = n + 2'd1;
          mode_nxt = sbl_pkg::M_ERROR;
        end
      end
    end

    // Final byte: flush, then end of source, then back to reset.
    if (fin) begin
      sbl_pkg::out_item_t fl;
      logic hf;
      hf = 1'b1;
      fl = '0;
      unique case (mode_nxt)
        sbl_pkg::M_SYMBOL: fl = mk(sym_kind(word_nxt, wlen_nxt), tstart_nxt, p1, 1'b0);
        sbl_pkg::M_NUMBER: fl = mk(sbl_pkg::K_NUMBER, tstart_nxt, p1, 1'b0);
        sbl_pkg::M_EQ:     fl = mk(sbl_pkg::K_EQUALS, tstart_nxt, sinc(tstart_nxt), 1'b0);
        sbl_pkg::M_PLUS:   fl = mk(sbl_pkg::K_PLUS, tstart_nxt, sinc(tstart_nxt), 1'b0);
        sbl_pkg::M_MINUS:  fl = mk(sbl_pkg::K_MINUS, tstart_nxt, sinc(tstart_nxt), 1'b0);
        sbl_pkg::M_LT, sbl_pkg::M_AMP, sbl_pkg::M_SLASH:
          fl = mk(sbl_pkg::K_FUNC, tstart_nxt, sinc(tstart_nxt), 1'b1);
        default: hf = 1'b0;
      endcase
      if (hf) begin
        if (n == 2'd0) r0 = fl; else r1 = fl;
        n = n + 2'd1;
      end
      unique case (n)
        2'd0: r0 = mk(sbl_pkg::K_END, p1, p1, 1'b0);
        2'd1: r1 = mk(sbl_pkg::K_END, p1, p1, 1'b0);
        default: r2 = mk(sbl_pkg::K_END, p1, p1, 1'b0);
      endcase
      n = n + 2'd1;
      mode_nxt = sbl_pkg::M_IDLE;
      word_nxt = '0;
      wlen_nxt = '0;
      pos_nxt = '0;
      tstart_nxt = '0;
    end else begin
      pos_nxt = p1;
    end

    // Mark the last record of this beat.
    unique case (n)
      2'd1: r0.run_last = 1'b1;
      2'd2: r1.run_last = 1'b1;
      2'd3: r2.run_last = 1'b1;
      default: ;
    endcase
    rec_cnt = n;
    rec[0] = r0;
    rec[1] = r1;
    rec[2] = r2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sbl_pkg::M_IDLE;
      word_r <= '0;
      wlen_r <= '0;
      pos_r <= '0;
      tstart_r <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      word_r <= word_nxt;
      wlen_r <= wlen_nxt;
      pos_r <= pos_nxt;
      tstart_r <= tstart_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    step && item.final_byte |=> mode_r == sbl_pkg::M_IDLE && pos_r == '0)
    else $error("lexer state not cleared after final byte");
  assert property (@(posedge clk) disable iff (!rst_n)
    step && item.final_byte |-> rec_cnt != 2'd0)
    else $error("final byte gave no end-of-source record");
  assert property (@(posedge clk) disable iff (!rst_n)
    wlen_r <= KC + 1'b1)
    else $error("word length beyond saturation");

endmodule

// ----- hw/rtl/sbl_queue.sv -----
// Result queue between the lexer front end and the output: takes up to three
// records per beat and hands out one per beat. Depends on sbl_pkg.
module sbl_queue #(
  parameter int DEPTH = sbl_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         wr_cnt,
  input  sbl_pkg::out_item_t wr_data [3],
  output logic               room,
  output logic               empty,
  input  logic               pop,
  output sbl_pkg::out_item_t rd_data
);

  localparam int AB = $clog2(DEPTH);

  sbl_pkg::out_item_t mem_r [DEPTH];
  logic [AB-1:0] wp_r, rp_r;
  logic [AB:0] cnt_r, cnt_nxt;
  logic do_pop;

  // Room for a full burst of three records.
  assign room = cnt_r <= (AB+1)'(DEPTH - 3);
  assign empty = cnt_r == '0;
  assign rd_data = mem_r[rp_r];
  assign do_pop = pop && !empty;
  assign cnt_nxt = cnt_r + (AB+1)'(wr_cnt) - (AB+1)'(do_pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      if (2'(i) < wr_cnt) mem_r[wp_r + AB'(i)] <= wr_data[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_r + AB'(wr_cnt);
      rp_r <= rp_r + AB'(do_pop);
      cnt_r <= cnt_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= (AB+1)'(DEPTH))
    else $error("result queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_cnt != 2'd0 |-> room)
    else $error("records written without room");
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_cnt == 2'd0 && !do_pop |=> $stable(cnt_r))
    else $error("queue count moved without traffic");

endmodule

// ----- hw/rtl/source_byte_lexer_core.sv -----
// Top level of the source byte lexer: front end plus result queue.
// A token's record is registered into the result queue with the byte that ends it.
// Throughput: one byte per cycle unless full; a byte yields up to three results,
// drained one per cycle from an eight-entry queue, which sets the sustained rate.
// Reset (rst_n low, synchronous): scan state, offsets and queue are cleared.
// Depends on sbl_pkg, sbl_front and sbl_queue.
module source_byte_lexer_core #(
  parameter int OFFSET_BITS   = sbl_pkg::OffsetBitsDef,
  parameter int KEYWORD_CHARS = sbl_pkg::KeywordCharsDef,
  parameter int QUEUE_DEPTH   = sbl_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  sbl_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output sbl_pkg::out_item_t out_item
);

  logic step, room;
  logic [1:0] rec_cnt, wr_cnt;
  sbl_pkg::out_item_t rec [3];

  assign full = !room;
  assign step = push && room;
  assign wr_cnt = step ? rec_cnt : 2'd0;

  sbl_front #(.OFFSET_BITS(OFFSET_BITS), .KEYWORD_CHARS(KEYWORD_CHARS)) u_front (
    .clk, .rst_n, .step, .item(in_item), .rec_cnt, .rec
  );

  sbl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .wr_cnt, .wr_data(rec), .room, .empty, .pop, .rd_data(out_item)
  );

endmodule
